>>> rtl/line_follow_pid_turn_controller_assert.svh
// Assertion macros for the line follower checker file
`ifndef LINE_FOLLOW_PID_TURN_CONTROLLER_ASSERT_SVH
`define LINE_FOLLOW_PID_TURN_CONTROLLER_ASSERT_SVH

// Concurrent check with a synchronous active-low reset guard
`define LFP_ASSERT(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("line follower check failed");

// Concurrent check that also holds through reset
`define LFP_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("line follower check failed");

`endif

>>> rtl/lfp_pkg.sv
// Shared types, constants and fixed-point helpers for the line follower
package lfp_pkg;

  localparam int FRAC_BITS = 8;
  localparam int ACC_W     = 34;

  typedef logic signed [15:0]      q16_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  typedef enum logic [1:0] {
    PH_STRAIGHT = 2'd0,
    PH_BRAKE    = 2'd1,
    PH_SPIN     = 2'd2,
    PH_STOP     = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    SQ_IDLE, SQ_SMO0, SQ_SMO1, SQ_INT, SQ_DER0, SQ_DER1,
    SQ_PID0, SQ_PID1, SQ_PID2, SQ_DONE
  } seq_t;

  typedef enum logic [2:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INTEG_GAIN = 3'd1,
    REG_DERIV_GAIN = 3'd2,
    REG_INTEG_SEP  = 3'd3,
    REG_DERIV_ALPHA = 3'd4,
    REG_BASE_SPEED = 3'd5,
    REG_SPIN_TMO   = 3'd6,
    REG_UNUSED     = 3'd7
  } reg_idx_t;

  // Shared multiply-accumulate control
  typedef struct packed {
    logic en;
    logic clr;
  } mac_ctl_t;

  localparam int ONE_Q      = 1 << FRAC_BITS;
  localparam int DZ_Q       = 4 * ONE_Q;
  localparam int LOST_Q     = 50 * ONE_Q;
  localparam int INTEG_LIM  = 18 * ONE_Q;
  localparam int PID_LIM    = 15 * ONE_Q;
  localparam int PID_LIM_LOST = 25 * ONE_Q;
  localparam int WHEEL_MAX  = 99 * ONE_Q;
  localparam int SMO_OLD    = 179;
  localparam int SMO_NEW    = 77;
  localparam int DECAY      = 243;
  localparam int PHASE_LEN  = 15;
  localparam int SPIN_ARM   = 200;
  localparam int HITS_EXIT  = 5;
  localparam int COOLDOWN   = 500;
  localparam int SPIN_SPEED = 37;
  localparam int STOP_SPEED = 120;

  // Arithmetic shift right that rounds toward zero
  function automatic acc_t shr_tz(input acc_t x);
    acc_t neg;
    begin
      neg = -x;
      if (x < 0) shr_tz = -(neg >>> FRAC_BITS);
      else       shr_tz = x >>> FRAC_BITS;
    end
  endfunction

  // Saturate to the 16-bit signed range
  function automatic q16_t sat16(input acc_t x);
    begin
      if (x > acc_t'(32767))       sat16 = 16'sh7FFF;
      else if (x < -acc_t'(32768)) sat16 = -16'sh8000;
      else                         sat16 = x[15:0];
    end
  endfunction

endpackage

>>> rtl/line_follow_pid_turn_controller.sv
// Top level: sensor decode, turn sequencer, PID sequencer and APB registers
//
//  channel   direction  handshake              payload
//  in_       input      in_valid / in_ready    five sensor flags
//  out_      output     out_valid / out_ready  wheel command, phase, lost flag
//  cfg_      input      APB write, pready = 1  seven control registers
//
// A straight tick runs from accept through eight passes through the shared
// multiplier (smoothing, integral, derivative, PID sum), then the result slot.
// Brake, spin and stop ticks go from accept straight to the result slot. in_ready is high only while idle.
// A held result stalls the next finished tick in its final state.
// Sync reset (rst_n low) clears state except work_r and payload; loads defaults.
module line_follow_pid_turn_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_sensor_far_left,
  input  logic        in_sensor_left,
  input  logic        in_sensor_center,
  input  logic        in_sensor_right,
  input  logic        in_sensor_far_right,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_left_reverse,
  output logic [6:0]  out_left_speed,
  output logic        out_right_drive,
  output logic        out_right_reverse,
  output logic [6:0]  out_right_speed,
  output logic [1:0]  out_active_phase,
  output logic        out_lost_line,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // configuration registers
  logic [11:0] kp_r, ki_r, kd_r;
  logic [6:0]  sep_r, base_r;
  logic [8:0]  alpha_r;
  logic [10:0] tmo_r;
  lfp_pkg::reg_idx_t cfg_idx;
  logic cfg_wr;

  // controller state
  lfp_pkg::seq_t   sq_r, sq_nxt;
  lfp_pkg::phase_t phase_r, phase_nxt;
  lfp_pkg::q16_t   raw_r, raw_nxt, last_r, last_nxt, smo_r, smo_nxt;
  lfp_pkg::q16_t   integ_r, integ_nxt, fd_r, fd_nxt, work_r, work_nxt;
  logic signed [6:0] lvo_r, lvo_nxt;
  logic        lost_r, lost_nxt;
  logic [10:0] ticks_r, ticks_nxt;
  logic [8:0]  cool_r, cool_nxt;
  logic [2:0]  hits_r, hits_nxt;

  // pending result and output slot
  logic        rlrev_r, rlrev_nxt, rrdrv_r, rrdrv_nxt, rrrev_r, rrrev_nxt;
  logic [6:0]  rlspd_r, rlspd_nxt, rrspd_r, rrspd_nxt;
  logic [1:0]  rran_r, rran_nxt;
  logic        ovld_r, ovld_nxt, olrev_r, olrev_nxt, ordrv_r, ordrv_nxt;
  logic        orrev_r, orrev_nxt, olost_r, olost_nxt;
  logic [6:0]  olspd_r, olspd_nxt, orspd_r, orspd_nxt;
  logic [1:0]  oph_r, oph_nxt;

  // shared unit
  lfp_pkg::mac_ctl_t  mac_ctl;
  logic signed [16:0] op_a;
  logic signed [12:0] op_b;
  lfp_pkg::acc_t      mac_sum;
  logic [8:0]         alpha_c;
  logic               accept, slot_free;

  lfp_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .op_a  (op_a),
    .op_b  (op_b),
    .sum   (mac_sum)
  );

  assign accept    = in_valid && in_ready;
  assign slot_free = !ovld_r || out_ready;
  assign alpha_c   = (alpha_r > 9'd256) ? 9'd256 : alpha_r;

  // APB register port
  assign cfg_pready = 1'b1;
  assign cfg_idx    = lfp_pkg::reg_idx_t'(cfg_paddr[4:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    case (cfg_idx)
      lfp_pkg::REG_PROP_GAIN:   cfg_prdata = {20'd0, kp_r};
      lfp_pkg::REG_INTEG_GAIN:  cfg_prdata = {20'd0, ki_r};
      lfp_pkg::REG_DERIV_GAIN:  cfg_prdata = {20'd0, kd_r};
      lfp_pkg::REG_INTEG_SEP:   cfg_prdata = {25'd0, sep_r};
      lfp_pkg::REG_DERIV_ALPHA: cfg_prdata = {23'd0, alpha_r};
      lfp_pkg::REG_BASE_SPEED:  cfg_prdata = {25'd0, base_r};
      lfp_pkg::REG_SPIN_TMO:    cfg_prdata = {21'd0, tmo_r};
      default:                  cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r <= 12'd640; ki_r <= 12'd20; kd_r <= 12'd102; sep_r <= 7'd15;
      alpha_r <= 9'd179; base_r <= 7'd41; tmo_r <= 11'd1000;
    end else if (cfg_wr) begin
      case (cfg_idx)
        lfp_pkg::REG_PROP_GAIN:   kp_r    <= cfg_pwdata[11:0];
        lfp_pkg::REG_INTEG_GAIN:  ki_r    <= cfg_pwdata[11:0];
        lfp_pkg::REG_DERIV_GAIN:  kd_r    <= cfg_pwdata[11:0];
        lfp_pkg::REG_INTEG_SEP:   sep_r   <= cfg_pwdata[6:0];
        lfp_pkg::REG_DERIV_ALPHA: alpha_r <= cfg_pwdata[8:0];
        lfp_pkg::REG_BASE_SPEED:  base_r  <= cfg_pwdata[6:0];
        lfp_pkg::REG_SPIN_TMO:    tmo_r   <= cfg_pwdata[10:0];
        default: ;
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    sq_nxt = sq_r;
    case (sq_r)
      lfp_pkg::SQ_IDLE: begin
        if (accept) begin
          if (phase_nxt == lfp_pkg::PH_STRAIGHT && phase_r == lfp_pkg::PH_STRAIGHT &&
              !(!in_sensor_far_left && cool_r == 9'd0)) sq_nxt = lfp_pkg::SQ_SMO0;
          else sq_nxt = lfp_pkg::SQ_DONE;
        end
      end
      lfp_pkg::SQ_SMO0: sq_nxt = lfp_pkg::SQ_SMO1;
      lfp_pkg::SQ_SMO1: sq_nxt = lfp_pkg::SQ_INT;
      lfp_pkg::SQ_INT:  sq_nxt = lfp_pkg::SQ_DER0;
      lfp_pkg::SQ_DER0: sq_nxt = lfp_pkg::SQ_DER1;
      lfp_pkg::SQ_DER1: sq_nxt = lfp_pkg::SQ_PID0;
      lfp_pkg::SQ_PID0: sq_nxt = lfp_pkg::SQ_PID1;
      lfp_pkg::SQ_PID1: sq_nxt = lfp_pkg::SQ_PID2;
      lfp_pkg::SQ_PID2: sq_nxt = lfp_pkg::SQ_DONE;
      lfp_pkg::SQ_DONE: if (slot_free) sq_nxt = lfp_pkg::SQ_IDLE;
      default:          sq_nxt = lfp_pkg::SQ_IDLE;
    endcase
  end

  // sequencer outputs: handshake and shared unit operands
  always_comb begin
    in_ready    = (sq_r == lfp_pkg::SQ_IDLE);
    mac_ctl.en  = 1'b1;
    mac_ctl.clr = 1'b1;
    op_a        = '0;
    op_b        = '0;
    case (sq_r)
      lfp_pkg::SQ_SMO0: begin
        op_a = 17'(smo_r); op_b = 13'(lfp_pkg::SMO_OLD);
      end
      lfp_pkg::SQ_SMO1: begin
        op_a = 17'(raw_r); op_b = 13'(lfp_pkg::SMO_NEW); mac_ctl.clr = 1'b0;
      end
      lfp_pkg::SQ_INT: begin
        op_a = 17'(integ_r); op_b = 13'(lfp_pkg::DECAY);
      end
      lfp_pkg::SQ_DER0: begin
        op_a = 17'(fd_r); op_b = $signed({4'd0, alpha_c});
      end
      lfp_pkg::SQ_DER1: begin
        op_a = 17'(work_r) - 17'(last_r);
        op_b = $signed({4'd0, 9'(9'd256 - alpha_c)});
        mac_ctl.clr = 1'b0;
      end
      lfp_pkg::SQ_PID0: begin
        op_a = 17'(work_r); op_b = $signed({1'b0, kp_r});
      end
      lfp_pkg::SQ_PID1: begin
        op_a = 17'(integ_r); op_b = $signed({1'b0, ki_r}); mac_ctl.clr = 1'b0;
      end
      lfp_pkg::SQ_PID2: begin
        op_a = 17'(fd_r); op_b = $signed({1'b0, kd_r}); mac_ctl.clr = 1'b0;
      end
      default: mac_ctl.en = 1'b0;
    endcase
  end

  // datapath: sensor stage, turn phases and PID commits
  always_comb begin
    lfp_pkg::q16_t s_new, w;
    lfp_pkg::acc_t t, pid, lim, lv, rv;
    logic [2:0] pat;
    logic done;
    phase_nxt = phase_r; raw_nxt = raw_r; last_nxt = last_r; smo_nxt = smo_r;
    integ_nxt = integ_r; fd_nxt = fd_r; work_nxt = work_r; lvo_nxt = lvo_r;
    lost_nxt = lost_r; ticks_nxt = ticks_r; cool_nxt = cool_r; hits_nxt = hits_r;
    rlrev_nxt = rlrev_r; rlspd_nxt = rlspd_r; rrdrv_nxt = rrdrv_r;
    rrrev_nxt = rrrev_r; rrspd_nxt = rrspd_r; rran_nxt = rran_r;
    s_new = smo_r; w = '0; t = '0; pid = '0; lim = '0; lv = '0; rv = '0;
    pat = {in_sensor_left, in_sensor_center, in_sensor_right};
    done = 1'b0;

    case (sq_r)
      lfp_pkg::SQ_IDLE: begin
        if (accept) begin
          // sensor stage
          if (phase_r == lfp_pkg::PH_STRAIGHT && !in_sensor_far_left && cool_r == 9'd0) begin
            phase_nxt = lfp_pkg::PH_BRAKE; ticks_nxt = '0; hits_nxt = '0;
            integ_nxt = '0; lost_nxt = 1'b0;
          end else if (!(in_sensor_far_left | in_sensor_left | in_sensor_center |
                         in_sensor_right | in_sensor_far_right)) begin
            lost_nxt = 1'b1;
            if (lvo_r > 0)      raw_nxt = 16'(lfp_pkg::LOST_Q);
            else if (lvo_r < 0) raw_nxt = -16'(lfp_pkg::LOST_Q);
          end else begin
            if (lost_r) begin
              lost_nxt = 1'b0; integ_nxt = '0; fd_nxt = '0;
            end
            case (pat)
              3'b010: begin raw_nxt = '0; lvo_nxt = 7'sd0; end
              3'b110: begin raw_nxt = -16'(10 * lfp_pkg::ONE_Q); lvo_nxt = -7'sd10; end
              3'b011: begin raw_nxt = 16'(10 * lfp_pkg::ONE_Q); lvo_nxt = 7'sd10; end
              3'b100: begin raw_nxt = -16'(30 * lfp_pkg::ONE_Q); lvo_nxt = -7'sd30; end
              3'b001: begin raw_nxt = 16'(30 * lfp_pkg::ONE_Q); lvo_nxt = 7'sd30; end
              default: ;
            endcase
          end

          // phase action
          rran_nxt = phase_nxt;
          rlrev_nxt = 1'b0; rlspd_nxt = '0; rrdrv_nxt = 1'b0;
          rrrev_nxt = 1'b0; rrspd_nxt = '0;
          case (phase_nxt)
            lfp_pkg::PH_STRAIGHT: begin
              if (cool_r != 9'd0) cool_nxt = cool_r - 9'd1;
            end
            lfp_pkg::PH_BRAKE: begin
              ticks_nxt = ticks_nxt + 11'd1;
              rlrev_nxt = 1'b1; rlspd_nxt = base_r; rrdrv_nxt = 1'b1;
              rrrev_nxt = 1'b1; rrspd_nxt = base_r;
              if (ticks_nxt >= 11'(lfp_pkg::PHASE_LEN)) begin
                phase_nxt = lfp_pkg::PH_SPIN; ticks_nxt = '0;
              end
            end
            lfp_pkg::PH_SPIN: begin
              ticks_nxt = ticks_nxt + 11'd1;
              rlspd_nxt = 7'(lfp_pkg::SPIN_SPEED); rrdrv_nxt = 1'b1;
              if (ticks_nxt > 11'(lfp_pkg::SPIN_ARM)) begin
                if (!in_sensor_center) begin
                  hits_nxt = hits_nxt + 3'd1;
                  if (hits_nxt >= 3'(lfp_pkg::HITS_EXIT)) begin
                    phase_nxt = lfp_pkg::PH_STOP; ticks_nxt = '0; done = 1'b1;
                  end
                end else begin
                  hits_nxt = '0;
                end
              end
              if (!done && ticks_nxt >= tmo_r) begin
                phase_nxt = lfp_pkg::PH_STOP; ticks_nxt = '0;
              end
            end
            default: begin
              ticks_nxt = ticks_nxt + 11'd1;
              rlrev_nxt = 1'b1; rlspd_nxt = 7'(lfp_pkg::STOP_SPEED);
              if (ticks_nxt >= 11'(lfp_pkg::PHASE_LEN)) begin
                phase_nxt = lfp_pkg::PH_STRAIGHT; ticks_nxt = '0;
                cool_nxt = 9'(lfp_pkg::COOLDOWN);
                integ_nxt = '0; smo_nxt = '0; fd_nxt = '0; raw_nxt = '0;
                last_nxt = '0; hits_nxt = '0;
              end
            end
          endcase
        end
      end

      // commit smoothed offset and select the working error
      lfp_pkg::SQ_SMO1: begin
        if (!lost_r) s_new = lfp_pkg::sat16(lfp_pkg::shr_tz(mac_sum));
        smo_nxt = s_new;
        w = lost_r ? raw_r : s_new;
        if (!lost_r && (s_new <= 16'sd0 ? -s_new : s_new) <= 16'(lfp_pkg::DZ_Q)) w = '0;
        work_nxt = w;
      end

      // integrate with separation, or decay inside the deadzone
      lfp_pkg::SQ_INT: begin
        t = lfp_pkg::acc_t'(work_r);
        if (t < 0) t = -t;
        if (t > lfp_pkg::acc_t'(lfp_pkg::DZ_Q)) begin
          if (t < lfp_pkg::acc_t'({sep_r, {lfp_pkg::FRAC_BITS{1'b0}}}))
            integ_nxt = lfp_pkg::sat16(lfp_pkg::acc_t'(integ_r) + lfp_pkg::acc_t'(work_r));
        end else begin
          integ_nxt = lfp_pkg::sat16(lfp_pkg::shr_tz(mac_sum));
        end
        if (integ_nxt > 16'(lfp_pkg::INTEG_LIM))       integ_nxt = 16'(lfp_pkg::INTEG_LIM);
        else if (integ_nxt < -16'(lfp_pkg::INTEG_LIM)) integ_nxt = -16'(lfp_pkg::INTEG_LIM);
      end

      // commit filtered derivative
      lfp_pkg::SQ_DER1: begin
        fd_nxt   = lfp_pkg::sat16(lfp_pkg::shr_tz(mac_sum));
        last_nxt = work_r;
      end

      // finish PID and wheel commands
      lfp_pkg::SQ_PID2: begin
        pid = lfp_pkg::shr_tz(mac_sum);
        lim = lost_r ? lfp_pkg::acc_t'(lfp_pkg::PID_LIM_LOST) : lfp_pkg::acc_t'(lfp_pkg::PID_LIM);
        if (pid > lim)       pid = lim;
        else if (pid < -lim) pid = -lim;
        lv = lfp_pkg::acc_t'({base_r, {lfp_pkg::FRAC_BITS{1'b0}}}) + pid;
        rv = lfp_pkg::acc_t'({base_r, {lfp_pkg::FRAC_BITS{1'b0}}}) - pid;
        if (lv < 0) lv = '0;
        else if (lv > lfp_pkg::acc_t'(lfp_pkg::WHEEL_MAX)) lv = lfp_pkg::acc_t'(lfp_pkg::WHEEL_MAX);
        if (rv < 0) rv = '0;
        else if (rv > lfp_pkg::acc_t'(lfp_pkg::WHEEL_MAX)) rv = lfp_pkg::acc_t'(lfp_pkg::WHEEL_MAX);
        rlspd_nxt = lv[lfp_pkg::FRAC_BITS +: 7];
        rrspd_nxt = rv[lfp_pkg::FRAC_BITS +: 7];
        rrdrv_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  // output slot: load a finished tick, drop on transfer
  always_comb begin
    ovld_nxt = ovld_r; olrev_nxt = olrev_r; olspd_nxt = olspd_r; ordrv_nxt = ordrv_r;
    orrev_nxt = orrev_r; orspd_nxt = orspd_r; oph_nxt = oph_r; olost_nxt = olost_r;
    if (ovld_r && out_ready) ovld_nxt = 1'b0;
    if (sq_r == lfp_pkg::SQ_DONE && slot_free) begin
      ovld_nxt = 1'b1; olrev_nxt = rlrev_r; olspd_nxt = rlspd_r; ordrv_nxt = rrdrv_r;
      orrev_nxt = rrrev_r; orspd_nxt = rrspd_r; oph_nxt = rran_r; olost_nxt = lost_r;
    end
  end

  assign out_valid         = ovld_r;
  assign out_left_reverse  = olrev_r;
  assign out_left_speed    = olspd_r;
  assign out_right_drive   = ordrv_r;
  assign out_right_reverse = orrev_r;
  assign out_right_speed   = orspd_r;
  assign out_active_phase  = oph_r;
  assign out_lost_line     = olost_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r <= lfp_pkg::SQ_IDLE; phase_r <= lfp_pkg::PH_STRAIGHT;
      raw_r <= '0; last_r <= '0; smo_r <= '0; integ_r <= '0; fd_r <= '0;
      lvo_r <= '0; lost_r <= 1'b0; ticks_r <= '0; cool_r <= '0; hits_r <= '0;
      ovld_r <= 1'b0;
    end else begin
      sq_r <= sq_nxt; phase_r <= phase_nxt;
      raw_r <= raw_nxt; last_r <= last_nxt; smo_r <= smo_nxt; integ_r <= integ_nxt;
      fd_r <= fd_nxt; lvo_r <= lvo_nxt; lost_r <= lost_nxt; ticks_r <= ticks_nxt;
      cool_r <= cool_nxt; hits_r <= hits_nxt; ovld_r <= ovld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    rlrev_r <= rlrev_nxt; rlspd_r <= rlspd_nxt; rrdrv_r <= rrdrv_nxt;
    rrrev_r <= rrrev_nxt; rrspd_r <= rrspd_nxt; rran_r <= rran_nxt;
    olrev_r <= olrev_nxt; olspd_r <= olspd_nxt; ordrv_r <= ordrv_nxt;
    orrev_r <= orrev_nxt; orspd_r <= orspd_nxt; oph_r <= oph_nxt; olost_r <= olost_nxt;
  end

endmodule

>>> rtl/lfp_mac.sv
// Shared multiply-accumulate unit used by every multiply step
module lfp_mac (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lfp_pkg::mac_ctl_t         ctl,
  input  logic signed [16:0]        op_a,
  input  logic signed [12:0]        op_b,
  output lfp_pkg::acc_t             sum
);

  lfp_pkg::acc_t acc_r;
  lfp_pkg::acc_t acc_nxt;
  logic signed [29:0] prod;

  // Multiply and add to the running sum, or start a new one
  always_comb begin
    prod    = op_a * op_b;
    sum     = (ctl.clr ? lfp_pkg::acc_t'(0) : acc_r) + lfp_pkg::acc_t'(prod);
    acc_nxt = ctl.en ? sum : acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

endmodule

>>> rtl/lfp_checker.sv
// Port-level checker for the line follower, bound to the top level
`include "line_follow_pid_turn_controller_assert.svh"

module lfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_left_reverse,
  input logic [6:0]  out_left_speed,
  input logic        out_right_drive,
  input logic        out_right_reverse,
  input logic [6:0]  out_right_speed,
  input logic [1:0]  out_active_phase
);

  // a held result stays valid and keeps its left wheel speed
  `LFP_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_left_speed))
  // the stop phase leaves the right wheel alone
  `LFP_ASSERT(a_stop_right, clk, rst_n, out_valid && out_active_phase == 2'd3 |-> !out_right_drive && out_right_speed == 7'd0)
  // straight driving is forward and within the wheel clamp
  `LFP_ASSERT(a_straight_cmd, clk, rst_n, out_valid && out_active_phase == 2'd0 |-> !out_left_reverse && out_left_speed <= 7'd99 && out_right_speed <= 7'd99)
  // brake reverses both wheels
  `LFP_ASSERT(a_brake_rev, clk, rst_n, out_valid && out_active_phase == 2'd1 |-> out_left_reverse && out_right_reverse)
  // an accepted tick keeps the block busy in the next cycle
  `LFP_ASSERT(a_busy, clk, rst_n, in_valid && in_ready |=> !in_ready)

endmodule

bind line_follow_pid_turn_controller lfp_checker u_lfp_checker (.*);
